// File: src/pffa_pkg.sv
package pffa_pkg;

   localparam int NumFramesDefault = 64;
   localparam int FrameIdWidth     = 6;

   // request kinds
   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_PIN   = 2'd2,
      KIND_UNPIN = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FIND_AGE,
      ST_FIND_FREE,
      ST_SCAN,
      ST_SHIFT_AGE,
      ST_SHIFT_FREE,
      ST_POP,
      ST_APPEND,
      ST_PUSH,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic init_step;   // write free_stack[idx] = idx during init sweep
      logic load_req;    // capture request word
      logic idx_clear;   // index counter to zero
      logic idx_top;     // index counter to top of free stack
      logic idx_inc;     // index counter +1
      logic pop_free;    // registered top-of-stack read becomes grant
      logic take_evict;  // current age entry becomes grant, mark evicted
      logic shift_age;   // age[idx] = age[idx+1]
      logic shift_free;  // free[idx] = free[idx+1]
      logic dec_age;     // age_count - 1
      logic dec_free;    // free_count - 1
      logic append;      // age[age_count] = grant, pin it
      logic push;        // free[free_count] = frame, unpin
      logic set_pin;
      logic clr_pin;
      logic set_fail;
      logic rsp_load;    // load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_done;
      logic kind_alloc;
      logic kind_free;
      logic kind_pin;
      logic in_range;
      logic free_empty;
      logic idx_at_age;     // idx >= age_count
      logic idx_at_free;    // idx >= free_count
      logic age_hit;        // age entry at idx matches frame
      logic free_hit;       // free entry at idx matches frame
      logic age_unpinned;   // age entry at idx is unpinned
   } sts_type;

endpackage

// File: src/pffa_datapath.sv
module pffa_datapath
   import pffa_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_tuser,
   input  logic [5:0]  req_tdata,
   output logic [7:0]  rsp_data
);

   localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW = $clog2(NUM_FRAMES + 1);

   // memories
   logic [IW-1:0] free_mem [NUM_FRAMES];
   logic [IW-1:0] age_mem  [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] pin_ff;

   logic [CW-1:0] free_cnt_ff, age_cnt_ff, idx_ff;
   logic [1:0]    kind_ff;
   logic [5:0]    fid_ff;
   logic [IW-1:0] grant_ff;
   logic          evict_ff, fail_ff;
   logic [7:0]    rsp_ff;

   // registered reads at idx and idx+1
   logic [IW-1:0] age_rd_ff, free_rd_ff, age_nx_ff, free_nx_ff;
   logic [CW-1:0] idx_in;
   logic [IW-1:0] frame_w;

   assign frame_w = IW'(fid_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) idx_in = '0;
      else if (cmd.idx_top) idx_in = free_cnt_ff - 1'b1;
      else if (cmd.idx_inc || cmd.init_step) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         free_cnt_ff <= CW'(NUM_FRAMES);
         age_cnt_ff  <= '0;
         pin_ff      <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.dec_age)  age_cnt_ff  <= age_cnt_ff - 1'b1;
         if (cmd.dec_free) free_cnt_ff <= free_cnt_ff - 1'b1;
         if (cmd.append) begin
            age_cnt_ff      <= age_cnt_ff + 1'b1;
            pin_ff[grant_ff] <= 1'b1;
         end
         if (cmd.push) begin
            free_cnt_ff      <= free_cnt_ff + 1'b1;
            pin_ff[frame_w] <= 1'b0;
         end
         if (cmd.set_pin) pin_ff[frame_w] <= 1'b1;
         if (cmd.clr_pin) pin_ff[frame_w] <= 1'b0;
      end
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (cmd.init_step) free_mem[idx_ff[IW-1:0]] <= idx_ff[IW-1:0];
      else if (cmd.shift_free) free_mem[idx_ff[IW-1:0]] <= free_nx_ff;
      else if (cmd.push) free_mem[free_cnt_ff[IW-1:0]] <= frame_w;
      free_rd_ff <= free_mem[idx_in[IW-1:0]];
      free_nx_ff <= free_mem[IW'(idx_in + 1'b1)];
   end

   // age list memory
   always_ff @(posedge clock) begin
      if (cmd.shift_age) age_mem[idx_ff[IW-1:0]] <= age_nx_ff;
      else if (cmd.append) age_mem[age_cnt_ff[IW-1:0]] <= grant_ff;
      age_rd_ff <= age_mem[idx_in[IW-1:0]];
      age_nx_ff <= age_mem[IW'(idx_in + 1'b1)];
   end

   // request, grant and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff  <= req_tuser;
         fid_ff   <= req_tdata;
         evict_ff <= 1'b0;
         fail_ff  <= 1'b0;
      end
      if (cmd.pop_free) grant_ff <= free_rd_ff;
      if (cmd.take_evict) begin
         grant_ff <= age_rd_ff;
         evict_ff <= 1'b1;
      end
      if (cmd.set_fail) fail_ff <= 1'b1;
      if (cmd.rsp_load) begin
         if (kind_ff == KIND_ALLOC) begin
            if (fail_ff) rsp_ff <= {1'b1, 1'b0, 6'd0};
            else rsp_ff <= {fail_ff, evict_ff, 6'(grant_ff)};
         end else begin
            rsp_ff <= {2'b00, fid_ff};
         end
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      sts.init_done     = (idx_ff == CW'(NUM_FRAMES - 1));
      sts.kind_alloc    = (kind_ff == KIND_ALLOC);
      sts.kind_free     = (kind_ff == KIND_FREE);
      sts.kind_pin      = (kind_ff == KIND_PIN);
      sts.in_range      = ({5'b0, fid_ff} < 11'(NUM_FRAMES));
      sts.free_empty    = (free_cnt_ff == '0);
      sts.idx_at_age    = (idx_ff >= age_cnt_ff);
      sts.idx_at_free   = (idx_ff >= free_cnt_ff);
      sts.age_hit       = (age_rd_ff == frame_w);
      sts.free_hit      = (free_rd_ff == frame_w);
      sts.age_unpinned  = !pin_ff[age_rd_ff];
   end

endmodule

// File: src/pffa_ctrl.sv
module pffa_ctrl
   import pffa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_free,   // output register can take a word
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_set
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else state_ff <= state_in;
   end

   // read data does not lag idx: the idx register drives memory addr
   // through idx_in, so reads reflect the current idx in each state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      rsp_set  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_done) begin
               cmd.init_step = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy          = 1'b0;
            cmd.idx_clear = 1'b1;
            if (req_fire) begin
               cmd.load_req = 1'b1;
               state_in     = ST_FIND_AGE;
            end
         end
         ST_FIND_AGE: begin
            // dispatch on first cycle (idx is 0, reads valid)
            if (sts.kind_alloc) begin
               if (!sts.free_empty) begin
                  cmd.idx_top  = 1'b1;
                  cmd.dec_free = 1'b1;
                  state_in     = ST_POP;
               end else begin
                  state_in = ST_SCAN;
               end
            end else if (!sts.in_range) begin
               state_in = ST_RESULT;
            end else if (!sts.kind_free) begin
               if (sts.kind_pin) cmd.set_pin = 1'b1;
               else cmd.clr_pin = 1'b1;
               state_in = ST_RESULT;
            end else if (sts.idx_at_age) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_FIND_FREE;
            end else if (sts.age_hit) begin
               cmd.dec_age = 1'b1;
               state_in    = ST_SHIFT_AGE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FIND_FREE: begin
            if (sts.idx_at_free) begin
               state_in = ST_PUSH;
            end else if (sts.free_hit) begin
               cmd.dec_free = 1'b1;
               state_in     = ST_SHIFT_FREE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SCAN: begin
            if (sts.idx_at_age) begin
               cmd.set_fail = 1'b1;
               state_in     = ST_RESULT;
            end else if (sts.age_unpinned) begin
               cmd.take_evict = 1'b1;
               cmd.dec_age    = 1'b1;
               state_in       = ST_SHIFT_AGE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SHIFT_AGE: begin
            // count already reduced; shift while idx < count
            if (sts.idx_at_age) begin
               state_in = sts.kind_alloc ? ST_APPEND : ST_PUSH;
            end else begin
               cmd.shift_age = 1'b1;
               cmd.idx_inc   = 1'b1;
            end
         end
         ST_SHIFT_FREE: begin
            if (sts.idx_at_free) begin
               state_in = ST_PUSH;
            end else begin
               cmd.shift_free = 1'b1;
               cmd.idx_inc    = 1'b1;
            end
         end
         ST_POP: begin
            // top of stack read is registered by now
            cmd.pop_free = 1'b1;
            state_in     = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_set      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/pinned_fifo_frame_allocator.sv
// Frame allocator: one response word per request word; the request kind
// travels on req_tuser. Pin, unpin, an out-of-range request and an alloc
// from the free stack need no walk; free and eviction walk the age list
// and free stack in a single shared index sequencer with one entry per
// cycle. A response held by rsp_tready low adds its stall cycles. After
// reset the free stack is filled by a sweep over all NUM_FRAMES entries
// while req_tready stays low. The response register lets a finished word
// wait while the next request is accepted.
module pinned_fifo_frame_allocator
   import pffa_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // frame_id[5:0], zero[7:6]
   input  logic [1:0] req_tuser,   // kind[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // granted_frame[5:0], was_evicted[6], status[7]
);

   cmd_type    cmd;
   sts_type    sts;
   logic       busy, rsp_set, rsp_valid_ff;
   logic [7:0] rsp_data;

   assign req_tready = !busy;

   pffa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_tvalid && req_tready),
      .rsp_free (!rsp_valid_ff || rsp_tready),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_set  (rsp_set)
   );

   pffa_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata[5:0]),
      .rsp_data  (rsp_data)
   );

   // output valid
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_set) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data;

endmodule

// File: tb/sv/pinned_fifo_frame_allocator_tb.sv
module pinned_fifo_frame_allocator_tb;
   import pffa_pkg::*;

   localparam int NFRAMES = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic       status;
      logic       was_evicted;
      logic [5:0] granted_frame;
   } grant_word_t;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // frame_id[5:0], zero[7:6]
   logic [1:0] req_tuser;   // kind[1:0]
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // granted_frame[5:0], was_evicted[6], status[7]

   // allocator state mirror
   logic [5:0] avail_frames[$];
   logic [5:0] aged_frames[$];
   logic       pinned[NFRAMES];

   grant_word_t expected_grants[$];
   int          mismatch_count;
   int          idle_pct;
   int          quiet_cycles;
   bit          timed_out;

   pinned_fifo_frame_allocator #(.NUM_FRAMES(NFRAMES)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // compute the response for one request and update the mirror
   function automatic grant_word_t predict_grant(input kind_type kind,
                                                 input logic [5:0] fid);
      grant_word_t r;
      bit          got;
      logic [5:0]  f;
      r = '{status: 1'b0, was_evicted: 1'b0, granted_frame: fid};
      got = 0;
      f = '0;
      if (kind == KIND_ALLOC) begin
         if (avail_frames.size() > 0) begin
            f = avail_frames.pop_back();
            got = 1;
         end else begin
            foreach (aged_frames[i]) begin
               if (!pinned[aged_frames[i]]) begin
                  f = aged_frames[i];
                  aged_frames.delete(i);
                  r.was_evicted = 1'b1;
                  got = 1;
                  break;
               end
            end
         end
         if (got) begin
            pinned[f] = 1'b1;
            aged_frames.push_back(f);
            r.granted_frame = f;
         end else begin
            r = '{status: 1'b1, was_evicted: 1'b0, granted_frame: 6'd0};
         end
      end else if (kind == KIND_FREE) begin
         foreach (aged_frames[i]) if (aged_frames[i] == fid) begin
            aged_frames.delete(i);
            break;
         end
         foreach (avail_frames[i]) if (avail_frames[i] == fid) begin
            avail_frames.delete(i);
            break;
         end
         avail_frames.push_back(fid);
         pinned[fid] = 1'b0;
      end else if (kind == KIND_PIN) begin
         pinned[fid] = 1'b1;
      end else begin
         pinned[fid] = 1'b0;
      end
      return r;
   endfunction

   // valid stays high after acceptance until the next word or an idle cycle
   task automatic send_request(input kind_type kind, input logic [5:0] fid);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, fid};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_grants.push_back(predict_grant(kind, fid));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_grants.size() > 0 && !timed_out) @(posedge clock);
   endtask

   // response checking and sink stalls
   always @(posedge clock) begin
      grant_word_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 0);
            end else begin
               want = expected_grants.pop_front();
               if (got.granted_frame !== want.granted_frame)
                  report_mismatch("granted_frame", got.granted_frame, want.granted_frame);
               if (got.was_evicted !== want.was_evicted)
                  report_mismatch("was_evicted", got.was_evicted, want.was_evicted);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("end of test: mismatches");
         $finish;
      end
   end

   // extremes, every kind, free of a free frame, pinning free frames
   task automatic test_directed();
      send_request(KIND_PIN, 6'd63);
      send_request(KIND_UNPIN, 6'd63);
      send_request(KIND_FREE, 6'd0);
      send_request(KIND_FREE, 6'd63);
      send_request(KIND_PIN, 6'd5);
      send_request(KIND_ALLOC, 6'd0);
      send_request(KIND_ALLOC, 6'd63);
      send_request(KIND_FREE, 6'd63);
      send_request(KIND_ALLOC, 6'd17);
      send_request(KIND_UNPIN, 6'd0);
   endtask

   // exhaust the pool, hit all-pinned failure, then evict
   task automatic test_exhaust_and_evict();
      repeat (NFRAMES + 2) send_request(KIND_ALLOC, 6'($urandom_range(63)));
      send_request(KIND_UNPIN, 6'd10);
      send_request(KIND_UNPIN, 6'd40);
      send_request(KIND_ALLOC, 6'd0);
      send_request(KIND_ALLOC, 6'd0);
      send_request(KIND_ALLOC, 6'd0);
      wait_drained();
   endtask

   // random mix weighted toward alloc, with frequent unpins to allow eviction
   task automatic test_random(input int count);
      int w;
      kind_type k;
      for (int n = 0; n < count; n++) begin
         idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 12;
         w = $urandom_range(99);
         k = (w < 40) ? KIND_ALLOC : (w < 55) ? KIND_FREE :
             (w < 70) ? KIND_PIN : KIND_UNPIN;
         send_request(k, 6'($urandom_range(63)));
      end
   endtask

   initial begin
      mismatch_count = 0;
      timed_out = 0;
      idle_pct = 12;
      quiet_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      for (int i = 0; i < NFRAMES; i++) begin
         avail_frames.push_back(i[5:0]);
         pinned[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_exhaust_and_evict();
      test_random(1650);
      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_grants.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
src/pffa_pkg.sv
src/pffa_datapath.sv
src/pffa_ctrl.sv
src/pinned_fifo_frame_allocator.sv
tb/sv/pinned_fifo_frame_allocator_tb.sv
